// ===== src/sms_pkg.sv =====
// shared constants, codes and types for the segmented load/store unit
// used by the decoder, the byte lane memories and the top level
package sms_pkg;

   localparam logic [31:0] TEXT_START     = 32'h0000_0000;
   localparam logic [31:0] DATA_START     = 32'h1000_0000;
   localparam logic [31:0] STACK_TOP      = 32'h7FFF_FFFC;
   localparam logic [31:0] SEGMENT_BYTES  = 32'h0004_0000;
   localparam logic [31:0] STACK_PHYS_TOP = 32'h0010_0000;
   localparam logic [31:0] DATA_PHYS_BASE = 32'h0004_0000;
   localparam logic [31:0] STACK_SPAN     = 32'h0008_0000;

   // physical byte addresses reach STACK_PHYS_TOP, plus three bytes of spill
   localparam int unsigned PHYS_W    = 21;
   localparam int unsigned LANES     = 4;
   localparam int unsigned ROW_DEPTH = 262145;
   localparam int unsigned ROW_W     = $clog2(ROW_DEPTH);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROW_DEPTH - 1);

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_STORE = 1'b1;

   localparam logic [1:0] SZ_BYTE = 2'd0;
   localparam logic [1:0] SZ_HALF = 2'd1;
   localparam logic [1:0] SZ_WORD = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_SEGV  = 2'd1;
   localparam logic [1:0] ST_ALIGN = 2'd2;

   typedef struct packed {
      logic                          is_store;
      logic [1:0]                    status;
      logic [31:0]                   fault_address;
      logic [1:0]                    size_code;
      logic [1:0]                    phys_lo;
      logic [LANES-1:0]              lane_en;
      logic [LANES-1:0][ROW_W-1:0]   row;
      logic [LANES-1:0][7:0]         wbyte;
   } dec_type;

endpackage

// ===== src/sms_if.sv =====
// valid/ready channels for request and response items
// self-contained, no package needed
interface sms_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [31:0] virt_address;
   logic [1:0]  size_code;
   logic [31:0] store_data;
   logic        align_check;

   modport source (output valid, opcode, virt_address, size_code, store_data, align_check,
                   input ready);
   modport sink   (input valid, opcode, virt_address, size_code, store_data, align_check,
                   output ready);
endinterface

interface sms_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] load_data;
   logic [1:0]  status;
   logic [31:0] fault_address;

   modport source (output valid, load_data, status, fault_address, input ready);
   modport sink   (input valid, load_data, status, fault_address, output ready);
endinterface

// ===== src/sms_bank.sv =====
// one byte lane of the physical store: one write and one registered read port
// depends on sms_pkg for the row count and address width
module sms_bank (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [sms_pkg::ROW_W-1:0] wr_row,
   input  logic [7:0]                wr_byte,
   input  logic                      rd_en,
   input  logic [sms_pkg::ROW_W-1:0] rd_row,
   output logic [7:0]                rd_byte
);

   logic [7:0] mem_ff [sms_pkg::ROW_DEPTH];
   logic [7:0] rd_byte_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_row] <= wr_byte;
      end
      if (rd_en) begin
         rd_byte_ff <= mem_ff[rd_row];
      end
   end

   assign rd_byte = rd_byte_ff;

endmodule

// ===== src/sms_decode.sv =====
// segment mapping, fault checks and per-lane row/byte selection for one item
// depends on sms_pkg for segment constants, codes and dec_type
module sms_decode (
   input  logic             opcode,
   input  logic [31:0]      virt_address,
   input  logic [1:0]       size_code,
   input  logic [31:0]      store_data,
   input  logic             align_check,
   output sms_pkg::dec_type dec
);

   logic        is_store;
   logic        text_hit;
   logic        data_hit;
   logic        stack_hit;
   logic [31:0] text_off;
   logic [31:0] data_off;
   logic [31:0] stack_off;
   logic [31:0] phys32;
   logic [sms_pkg::PHYS_W-1:0] phys;
   logic        misalign;
   logic        low_bits;

   assign is_store  = (opcode == sms_pkg::OP_STORE);
   assign text_off  = virt_address - sms_pkg::TEXT_START;
   assign data_off  = virt_address - sms_pkg::DATA_START;
   assign stack_off = sms_pkg::STACK_TOP - virt_address;

   assign text_hit  = !is_store && (text_off < sms_pkg::SEGMENT_BYTES);
   assign data_hit  = data_off < sms_pkg::SEGMENT_BYTES;
   assign stack_hit = (virt_address <= sms_pkg::STACK_TOP) && (stack_off <= sms_pkg::STACK_SPAN);

   always_comb begin
      if (text_hit) begin
         phys32 = text_off;
      end else if (data_hit) begin
         phys32 = sms_pkg::DATA_PHYS_BASE + data_off;
      end else begin
         phys32 = sms_pkg::STACK_PHYS_TOP - stack_off;
      end
   end

   assign phys = phys32[sms_pkg::PHYS_W-1:0];

   // alignment is judged on the virtual address
   always_comb begin
      case (size_code)
         sms_pkg::SZ_BYTE: low_bits = 1'b0;
         sms_pkg::SZ_HALF: low_bits = virt_address[0];
         sms_pkg::SZ_WORD: low_bits = |virt_address[1:0];
         default:          low_bits = 1'b1;
      endcase
   end

   assign misalign = (size_code != sms_pkg::SZ_BYTE && size_code != sms_pkg::SZ_HALF &&
                      size_code != sms_pkg::SZ_WORD) || (align_check && low_bits);

   always_comb begin
      logic [1:0] k;
      logic       used;
      dec.is_store  = is_store;
      dec.size_code = size_code;
      dec.phys_lo   = phys[1:0];
      if (!(text_hit || data_hit || stack_hit)) begin
         dec.status        = sms_pkg::ST_SEGV;
         dec.fault_address = virt_address;
      end else if (misalign) begin
         dec.status        = sms_pkg::ST_ALIGN;
         dec.fault_address = 32'(phys);
      end else begin
         dec.status        = sms_pkg::ST_OK;
         dec.fault_address = '0;
      end
      // lane j carries access byte k, where lane = phys + k modulo four
      for (int j = 0; j < sms_pkg::LANES; j++) begin
         k    = 2'(j) - phys[1:0];
         used = (k == 2'd0) ||
                (k == 2'd1 && size_code != sms_pkg::SZ_BYTE) ||
                (k[1] && size_code == sms_pkg::SZ_WORD);
         dec.lane_en[j] = used && (dec.status == sms_pkg::ST_OK);
         dec.row[j]     = phys[sms_pkg::PHYS_W-1:2] + sms_pkg::ROW_W'(2'(j) < phys[1:0]);
         dec.wbyte[j]   = store_data[8*k +: 8];
      end
   end

endmodule

// ===== src/segmented_memory_load_store.sv =====
// segmented load/store unit over a four-lane byte store
// a request goes through the decode register and the memory read register to its response
// throughput: one item per cycle unless stalled; an item uses each lane memory at most once
// reset: clears control state, then sweeps all 262145 rows of the lane memories to zero,
// one row a cycle, with req.ready low until the sweep ends
module segmented_memory_load_store (
   input  logic      clock,
   input  logic      reset,
   sms_req_if.sink   req,
   sms_rsp_if.source rsp
);

   sms_pkg::dec_type dec;
   sms_pkg::dec_type dec_ff;

   logic                      clr_active_ff, clr_active_in;
   logic [sms_pkg::ROW_W-1:0] clr_row_ff, clr_row_in;
   logic                      d_valid_ff, d_valid_in;
   logic                      m_valid_ff, m_valid_in;
   logic                      m_is_store_ff;
   logic [1:0]                m_status_ff;
   logic [31:0]               m_fault_ff;
   logic [1:0]                m_size_ff;
   logic [1:0]                m_phys_lo_ff;

   logic                                 advance;
   logic                                 issue;
   logic                                 accept;
   logic [sms_pkg::LANES-1:0][7:0]       rd_byte;
   logic [31:0]                          load_word;

   sms_decode u_decode (
      .opcode       (req.opcode),
      .virt_address (req.virt_address),
      .size_code    (req.size_code),
      .store_data   (req.store_data),
      .align_check  (req.align_check),
      .dec          (dec)
   );

   assign advance   = !m_valid_ff || rsp.ready;
   assign issue     = d_valid_ff && advance;
   assign req.ready = !clr_active_ff && (!d_valid_ff || advance);
   assign accept    = req.valid && req.ready;

   assign d_valid_in    = accept || (d_valid_ff && !advance);
   assign m_valid_in    = issue || (m_valid_ff && !rsp.ready);
   assign clr_active_in = clr_active_ff && (clr_row_ff != sms_pkg::ROW_LAST);
   assign clr_row_in    = clr_row_ff + sms_pkg::ROW_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_row_ff    <= '0;
         d_valid_ff    <= 1'b0;
         m_valid_ff    <= 1'b0;
      end else begin
         clr_active_ff <= clr_active_in;
         if (clr_active_ff) begin
            clr_row_ff <= clr_row_in;
         end
         d_valid_ff <= d_valid_in;
         m_valid_ff <= m_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dec_ff <= dec;
      end
      if (issue) begin
         m_is_store_ff <= dec_ff.is_store;
         m_status_ff   <= dec_ff.status;
         m_fault_ff    <= dec_ff.fault_address;
         m_size_ff     <= dec_ff.size_code;
         m_phys_lo_ff  <= dec_ff.phys_lo;
      end
   end

   for (genvar j = 0; j < sms_pkg::LANES; j++) begin : g_lane
      sms_bank u_bank (
         .clock   (clock),
         .wr_en   (clr_active_ff || (issue && dec_ff.is_store && dec_ff.lane_en[j])),
         .wr_row  (clr_active_ff ? clr_row_ff : dec_ff.row[j]),
         .wr_byte (clr_active_ff ? 8'h00 : dec_ff.wbyte[j]),
         .rd_en   (issue && !dec_ff.is_store && dec_ff.lane_en[j]),
         .rd_row  (dec_ff.row[j]),
         .rd_byte (rd_byte[j])
      );
   end

   // rotate lanes back into access order and drop bytes beyond the size
   always_comb begin
      logic [1:0] lane;
      logic       used;
      load_word = '0;
      for (int k = 0; k < sms_pkg::LANES; k++) begin
         lane = m_phys_lo_ff + 2'(k);
         used = (k == 0) ||
                (k == 1 && m_size_ff != sms_pkg::SZ_BYTE) ||
                (k >= 2 && m_size_ff == sms_pkg::SZ_WORD);
         load_word[8*k +: 8] = used ? rd_byte[lane] : 8'h00;
      end
   end

   assign rsp.valid         = m_valid_ff;
   assign rsp.status        = m_status_ff;
   assign rsp.fault_address = m_fault_ff;
   assign rsp.load_data     = (m_status_ff == sms_pkg::ST_OK && !m_is_store_ff) ? load_word : '0;

`ifndef NO_ASSERTIONS
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !(req.valid && req.ready))
      else $error("item accepted during clearing pass");

   a_load_reaches_output: assert property (@(posedge clock) disable iff (reset)
      issue && !dec_ff.is_store && dec_ff.status == sms_pkg::ST_OK
      |=> rsp.valid && rsp.status == sms_pkg::ST_OK && !m_is_store_ff)
      else $error("issued load did not reach the output register");

   a_lane_count: assert property (@(posedge clock) disable iff (reset)
      d_valid_ff && dec_ff.status == sms_pkg::ST_OK
      |-> (dec_ff.size_code == sms_pkg::SZ_BYTE && $countones(dec_ff.lane_en) == 1) ||
          (dec_ff.size_code == sms_pkg::SZ_HALF && $countones(dec_ff.lane_en) == 2) ||
          (dec_ff.size_code == sms_pkg::SZ_WORD && $countones(dec_ff.lane_en) == 4))
      else $error("lane enables do not match access size");

   a_fault_no_lanes: assert property (@(posedge clock) disable iff (reset)
      d_valid_ff && dec_ff.status != sms_pkg::ST_OK |-> dec_ff.lane_en == '0)
      else $error("faulting item touches the store");

   a_fault_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status != sms_pkg::ST_OK |-> rsp.load_data == '0)
      else $error("load data not zero on fault");
`endif

endmodule
